// ===== src/i2ctrb_pkg.sv =====
package i2ctrb_pkg;

  localparam int MAX_DEVICES     = 16;
  localparam int REGS_PER_DEVICE = 256;
  localparam int MAX_BURST       = 64;

  localparam int BYTE_W      = 8;
  localparam int CMD_W       = 3;
  localparam int STATUS_W    = 2;
  localparam int COUNT_FLD_W = 7;
  localparam int DEVCNT_W    = 5;

  // register numbers wrap by truncation, so the register count is a power of two
  localparam int REG_W       = $clog2(REGS_PER_DEVICE);
  localparam int SLOT_W      = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
  localparam int STORE_DEPTH = MAX_DEVICES * REGS_PER_DEVICE;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CNT_W       = $clog2(MAX_BURST + 1);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_ADDR_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ADDR_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEV_COUNT = 2'd2;

  typedef enum logic [CMD_W-1:0] {
    CMD_BEGIN       = 3'd0,
    CMD_PING        = 3'd1,
    CMD_WRITE_REG   = 3'd2,
    CMD_READ_REG    = 3'd3,
    CMD_BURST_READ  = 3'd4,
    CMD_BURST_WRITE = 3'd5
  } cmd_code_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 2'd0,
    ST_NODEV       = 2'd1,
    ST_NOTSTARTED  = 2'd2
  } status_code_t;

  typedef struct packed {
    logic                load_item;
    logic                clear_step;
    logic                set_started;
    logic                do_write;
    logic                rd_issue;
    logic                out_single;
    logic [STATUS_W-1:0] out_status;
    logic                out_data;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             started;
    logic             found;
    logic             clear_done;
    logic             out_free;
    logic             burst_last;
  } dp_status_t;

endpackage

// ===== src/i2c_target_register_bank.sv =====
// single-result commands: item registered, result loads once output register is free
// register read: the result also passes through the registered store read port
// burst read, n bytes: one byte per cycle from the store read port while output is free
// reset: synchronous, clears config and bus state, then a clearing pass zeroes the
// 4096-entry store one entry per cycle with in_tready low; config writes go on
module i2c_target_register_bank import i2ctrb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // device_address[7:0], register_index[15:8], write_value[23:16], byte_offset[31:24],
  // byte_count[38:32], zero[39]
  input  logic [39:0]           in_tdata,
  // command[2:0]
  input  logic [CMD_W-1:0]      in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // read_data[7:0]
  output logic [BYTE_W-1:0]     out_tdata,
  // status[1:0]
  output logic [STATUS_W-1:0]   out_tuser,
  output logic                  out_tlast,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  ctrl_cmd_t  ctl;
  dp_status_t sts;

  i2ctrb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .ctl      (ctl)
  );

  i2ctrb_datapath u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .ctl                 (ctl),
    .sts                 (sts),
    .item_command        (in_tuser),
    .item_device_address (in_tdata[7:0]),
    .item_register_index (in_tdata[15:8]),
    .item_write_value    (in_tdata[23:16]),
    .item_byte_offset    (in_tdata[31:24]),
    .item_byte_count     (in_tdata[38:32]),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .out_ready           (out_tready),
    .out_valid           (out_tvalid),
    .out_status          (out_tuser),
    .out_read_data       (out_tdata),
    .out_last            (out_tlast)
  );

  // a new result only goes into a free output register
  a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.out_single || ctl.out_data) |-> (!out_tvalid || out_tready))
    else $error("result loaded over a pending result");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("item accepted while another is in flight");

  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.clear_step |-> !in_tready)
    else $error("input open during store clearing");

  a_no_rw_mix: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.do_write |-> (!ctl.rd_issue && !ctl.clear_step))
    else $error("store write collides with read or clear");

endmodule

// ===== src/i2ctrb_ram.sv =====
module i2ctrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/i2ctrb_datapath.sv =====
module i2ctrb_datapath import i2ctrb_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ctrl_cmd_t              ctl,
  output dp_status_t             sts,
  input  logic [CMD_W-1:0]       item_command,
  input  logic [BYTE_W-1:0]      item_device_address,
  input  logic [BYTE_W-1:0]      item_register_index,
  input  logic [BYTE_W-1:0]      item_write_value,
  input  logic [BYTE_W-1:0]      item_byte_offset,
  input  logic [COUNT_FLD_W-1:0] item_byte_count,
  input  logic                   cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic [STATUS_W-1:0]    out_status,
  output logic [BYTE_W-1:0]      out_read_data,
  output logic                   out_last
);

  logic [CMD_W-1:0]      cmd_r;
  logic [BYTE_W-1:0]     addr_r;
  logic [REG_W-1:0]      reg_r;
  logic [BYTE_W-1:0]     wval_r;
  logic [REG_W-1:0]      off_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [CNT_W-1:0]      idx_r;
  logic [CNT_W-1:0]      cnt_nxt;
  logic                  started_r;
  logic [CFG_DATA_W-1:0] addr_low_r;
  logic [CFG_DATA_W-1:0] addr_high_r;
  logic [DEVCNT_W-1:0]   dev_count_r;
  logic [ADDR_W-1:0]     clr_addr_r;
  logic                  out_valid_r;
  logic [STATUS_W-1:0]   out_status_r;
  logic [BYTE_W-1:0]     out_data_r;
  logic                  out_last_r;

  logic [2*CFG_DATA_W-1:0] addr_table;
  logic [DEVCNT_W-1:0]     active_count;
  logic [SLOT_W-1:0]       slot;
  logic                    found;
  logic [REG_W-1:0]        wr_reg;
  logic [REG_W-1:0]        rd_reg;
  logic [ADDR_W-1:0]       slot_base;
  logic [ADDR_W-1:0]       mem_waddr;
  logic [ADDR_W-1:0]       mem_raddr;
  logic [BYTE_W-1:0]       mem_wdata;
  logic [BYTE_W-1:0]       mem_rdata;
  logic                    mem_we;
  logic                    out_free;

  assign addr_table   = {addr_high_r, addr_low_r};
  assign active_count = (dev_count_r > DEVCNT_W'(MAX_DEVICES)) ? DEVCNT_W'(MAX_DEVICES)
                                                               : dev_count_r;

  // lowest active slot with a matching address wins
  always_comb begin
    slot  = '0;
    found = 1'b0;
    for (int s = MAX_DEVICES - 1; s >= 0; s--) begin
      if ((DEVCNT_W'(s) < active_count) && (addr_table[BYTE_W*s +: BYTE_W] == addr_r)) begin
        slot  = SLOT_W'(s);
        found = 1'b1;
      end
    end
  end

  always_comb begin
    if (item_byte_count == '0) begin
      cnt_nxt = CNT_W'(1);
    end else if (item_byte_count > COUNT_FLD_W'(MAX_BURST)) begin
      cnt_nxt = CNT_W'(MAX_BURST);
    end else begin
      cnt_nxt = CNT_W'(item_byte_count);
    end
    // a single register read is a burst of one
    if (item_command == CMD_READ_REG) begin
      cnt_nxt = CNT_W'(1);
    end
  end

  assign wr_reg    = reg_r + ((cmd_r == CMD_BURST_WRITE) ? off_r : '0);
  assign rd_reg    = reg_r + REG_W'(idx_r);
  assign slot_base = ADDR_W'(slot) * ADDR_W'(REGS_PER_DEVICE);

  assign mem_we    = ctl.clear_step | ctl.do_write;
  assign mem_waddr = ctl.clear_step ? clr_addr_r : (slot_base + ADDR_W'(wr_reg));
  assign mem_wdata = ctl.clear_step ? '0 : wval_r;
  assign mem_raddr = slot_base + ADDR_W'(rd_reg);

  i2ctrb_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (ctl.rd_issue),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r   <= 1'b0;
      addr_low_r  <= '0;
      addr_high_r <= '0;
      dev_count_r <= '0;
      clr_addr_r  <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_ADDR_LOW:  addr_low_r  <= cfg_wdata;
          CFG_ADDR_HIGH: addr_high_r <= cfg_wdata;
          CFG_DEV_COUNT: dev_count_r <= cfg_wdata[DEVCNT_W-1:0];
          default: ;
        endcase
      end
      if (ctl.clear_step) begin
        clr_addr_r <= clr_addr_r + ADDR_W'(1);
      end
      if (ctl.set_started) begin
        started_r <= 1'b1;
      end
      if (ctl.load_item) begin
        idx_r <= '0;
      end else if (ctl.rd_issue) begin
        idx_r <= idx_r + CNT_W'(1);
      end
      if (ctl.out_single || ctl.out_data) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_item) begin
      cmd_r  <= item_command;
      addr_r <= item_device_address;
      reg_r  <= item_register_index[REG_W-1:0];
      wval_r <= item_write_value;
      off_r  <= item_byte_offset[REG_W-1:0];
      cnt_r  <= cnt_nxt;
    end
    if (ctl.out_single) begin
      out_status_r <= ctl.out_status;
      out_data_r   <= '0;
      out_last_r   <= 1'b1;
    end else if (ctl.out_data) begin
      out_status_r <= ST_OK;
      out_data_r   <= mem_rdata;
      out_last_r   <= (idx_r == cnt_r);
    end
  end

  assign sts.cmd        = cmd_r;
  assign sts.started    = started_r;
  assign sts.found      = found;
  assign sts.clear_done = (clr_addr_r == ADDR_W'(STORE_DEPTH - 1));
  assign sts.out_free   = out_free;
  assign sts.burst_last = (idx_r == cnt_r);

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_read_data = out_data_r;
  assign out_last      = out_last_r;

endmodule

// ===== src/i2ctrb_ctrl.sv =====
module i2ctrb_ctrl import i2ctrb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t sts,
  output ctrl_cmd_t  ctl
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_DATA
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   is_read;
  logic   is_write;

  assign in_ready = (state_r == S_IDLE);
  assign is_read  = (sts.cmd == CMD_READ_REG) || (sts.cmd == CMD_BURST_READ);
  assign is_write = (sts.cmd == CMD_WRITE_REG) || (sts.cmd == CMD_BURST_WRITE);

  always_comb begin
    ctl       = '0;
    ctl.out_status = ST_OK;
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        ctl.clear_step = 1'b1;
        if (sts.clear_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          ctl.load_item = 1'b1;
          state_nxt     = S_EXEC;
        end
      end
      S_EXEC: begin
        if (is_read && sts.started && sts.found) begin
          ctl.rd_issue = 1'b1;
          state_nxt    = S_DATA;
        end else if (sts.out_free) begin
          ctl.out_single = 1'b1;
          state_nxt      = S_IDLE;
          if (sts.cmd == CMD_BEGIN) begin
            ctl.set_started = 1'b1;
          end else if (sts.cmd > CMD_BURST_WRITE) begin
            ctl.out_status = ST_OK;
          end else if (!sts.started) begin
            ctl.out_status = ST_NOTSTARTED;
          end else if (!sts.found) begin
            ctl.out_status = ST_NODEV;
          end else begin
            ctl.do_write = is_write;
          end
        end
      end
      S_DATA: begin
        // read data holds in the ram output until the next read
        if (sts.out_free) begin
          ctl.out_data = 1'b1;
          if (sts.burst_last) begin
            state_nxt = S_IDLE;
          end else begin
            ctl.rd_issue = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== tb/i2c_target_register_bank_tb.sv =====
`timescale 1ns / 1ps

module i2c_target_register_bank_tb;
  import i2ctrb_pkg::*;

  // command codes outside the defined set, the bank answers them with a plain ok
  localparam logic [CMD_W-1:0] CMD_UNKNOWN_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNKNOWN_7 = 3'd7;

  localparam int N_SCRIPT    = 25;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [CMD_W-1:0]       cmd;
    logic [BYTE_W-1:0]      dev;
    logic [BYTE_W-1:0]      regn;
    logic [BYTE_W-1:0]      wval;
    logic [BYTE_W-1:0]      off;
    logic [COUNT_FLD_W-1:0] cnt;
  } bus_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] st;
    logic [BYTE_W-1:0]   rd;
    logic                last;
  } reply_t;

  typedef struct packed {
    bus_item_t           item;
    logic                typed;
    logic [STATUS_W-1:0] st;
    logic [BYTE_W-1:0]   rd;
  } script_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [39:0]           in_tdata;
  logic [CMD_W-1:0]      in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [BYTE_W-1:0]     out_tdata;
  logic [STATUS_W-1:0]   out_tuser;
  logic                  out_tlast;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  i2c_target_register_bank u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // local copy of the bank
  logic [63:0]         addr_lo;
  logic [63:0]         addr_hi;
  logic [DEVCNT_W-1:0] dev_count;
  bit                  started;
  logic [BYTE_W-1:0]   reg_image [STORE_DEPTH];

  reply_t      pending_replies [$];
  script_row_t script [N_SCRIPT];
  int          mismatches;
  int          checked;
  int          items_sent;
  int          burst_reads;
  int          burst_left;
  int          ready_mode;
  int          mode_left;

  function automatic logic [BYTE_W-1:0] slot_addr(int s);
    logic [63:0] w;
    w = (s < 8) ? addr_lo : addr_hi;
    return w[(s % 8) * 8 +: 8];
  endfunction

  // lowest active slot whose address matches, -1 if none
  function automatic int match_slot(logic [BYTE_W-1:0] dev);
    int n;
    n = (dev_count > MAX_DEVICES) ? MAX_DEVICES : int'(dev_count);
    for (int s = 0; s < n; s++) begin
      if (slot_addr(s) == dev) return s;
    end
    return -1;
  endfunction

  function automatic reply_t single(logic [STATUS_W-1:0] st);
    return '{st, 8'h00, 1'b1};
  endfunction

  task automatic predict_replies(input bus_item_t it, input bit keep);
    reply_t           r [$];
    int               slot;
    int               n;
    logic [REG_W-1:0] rn;
    if (it.cmd == CMD_BEGIN) begin
      started = 1'b1;
      r.push_back(single(ST_OK));
    end else if (it.cmd > CMD_BURST_WRITE) begin
      r.push_back(single(ST_OK));
    end else if (!started) begin
      r.push_back(single(ST_NOTSTARTED));
    end else begin
      slot = match_slot(it.dev);
      if (slot < 0) begin
        r.push_back(single(ST_NODEV));
      end else begin
        case (it.cmd)
          CMD_PING: begin
            r.push_back(single(ST_OK));
          end
          CMD_WRITE_REG: begin
            reg_image[slot * REGS_PER_DEVICE + int'(it.regn)] = it.wval;
            r.push_back(single(ST_OK));
          end
          CMD_READ_REG: begin
            r.push_back('{ST_OK, reg_image[slot * REGS_PER_DEVICE + int'(it.regn)], 1'b1});
          end
          CMD_BURST_READ: begin
            n = (it.cnt == 0) ? 1 : (it.cnt > MAX_BURST) ? MAX_BURST : int'(it.cnt);
            for (int i = 0; i < n; i++) begin
              rn = REG_W'(int'(it.regn) + i);
              r.push_back('{ST_OK, reg_image[slot * REGS_PER_DEVICE + int'(rn)], i == n - 1});
            end
          end
          default: begin
            rn = it.regn + it.off;
            reg_image[slot * REGS_PER_DEVICE + int'(rn)] = it.wval;
            r.push_back(single(ST_OK));
          end
        endcase
      end
    end
    if (keep) begin
      foreach (r[k]) pending_replies.push_back(r[k]);
    end
  endtask

  function automatic void note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
  endfunction

  always @(posedge clk) begin
    reply_t want;
    if (rst_n && out_tvalid && out_tready) begin
      checked++;
      if (pending_replies.size() == 0) begin
        note_mismatch($sformatf("unexpected result: status %0d data %02h last %0d",
                                out_tuser, out_tdata, out_tlast));
      end else begin
        want = pending_replies.pop_front();
        if (want.st !== out_tuser || want.rd !== out_tdata || want.last !== out_tlast) begin
          note_mismatch($sformatf(
            "result mismatch: expected status %0d data %02h last %0d, got %0d %02h %0d",
            want.st, want.rd, want.last, out_tuser, out_tdata, out_tlast));
        end
      end
    end
  end

  // result side stall pattern, switches mode now and then
  always @(negedge clk) begin
    if (mode_left == 0) begin
      ready_mode = $urandom_range(0, 3);
      mode_left  = $urandom_range(16, 120);
    end
    mode_left--;
    case (ready_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= 1'($urandom_range(0, 1));
      2:       out_tready <= ($urandom_range(0, 3) == 0);
      default: out_tready <= ($urandom_range(0, 4) != 0);
    endcase
  end

  // called at a falling edge, returns at the falling edge after the item is taken
  task automatic put_item(input bus_item_t it, input bit typed, input reply_t fixed);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, it.cnt, it.off, it.wval, it.regn, it.dev};
    in_tuser  <= it.cmd;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    if (it.cmd == CMD_BURST_READ) burst_reads++;
    predict_replies(it, !typed);
    if (typed) pending_replies.push_back(fixed);
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    burst_left = 0;
  endtask

  task automatic set_bank(input logic [63:0] lo, input logic [63:0] hi,
                          input logic [DEVCNT_W-1:0] cnt);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_ADDR_LOW;
    cfg_wdata <= lo;
    @(negedge clk);
    cfg_index <= CFG_ADDR_HIGH;
    cfg_wdata <= hi;
    @(negedge clk);
    cfg_index <= CFG_DEV_COUNT;
    cfg_wdata <= CFG_DATA_W'(cnt);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    addr_lo   = lo;
    addr_hi   = hi;
    dev_count = cnt;
  endtask

  function automatic bus_item_t rand_item(logic [BYTE_W-1:0] hot);
    bus_item_t it;
    int        pick;
    pick = $urandom_range(0, 99);
    it.cmd = (pick < 3)  ? CMD_BEGIN :
             (pick < 13) ? CMD_PING :
             (pick < 35) ? CMD_WRITE_REG :
             (pick < 55) ? CMD_READ_REG :
             (pick < 72) ? CMD_BURST_READ : CMD_BURST_WRITE;
    it.dev  = ($urandom_range(0, 4) == 0) ? BYTE_W'($urandom) : slot_addr($urandom_range(0, 15));
    // half the accesses land near a hot spot so reads see earlier writes
    it.regn = $urandom_range(0, 1) ? hot + BYTE_W'($urandom_range(0, 7)) : BYTE_W'($urandom);
    it.wval = BYTE_W'($urandom);
    it.off  = $urandom_range(0, 1) ? BYTE_W'($urandom_range(0, 7)) : BYTE_W'($urandom);
    pick = $urandom_range(0, 9);
    it.cnt = (pick < 6) ? COUNT_FLD_W'($urandom_range(1, 8)) :
             (pick == 6) ? COUNT_FLD_W'(0) :
             (pick == 7) ? COUNT_FLD_W'(MAX_BURST) :
             COUNT_FLD_W'($urandom_range(0, MAX_BURST));
    return it;
  endfunction

  task automatic random_run(input int n);
    logic [BYTE_W-1:0] hot;
    hot = BYTE_W'($urandom);
    repeat (n) put_item(rand_item(hot), 1'b0, '0);
    drain();
  endtask

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    out_tready = 1'b0;
    cfg_wr_en  = 1'b0;
    cfg_index  = '0;
    cfg_wdata  = '0;
    addr_lo    = '0;
    addr_hi    = '0;
    dev_count  = '0;
    started    = 1'b0;
    foreach (reg_image[k]) reg_image[k] = '0;

    // not-started errors and an unknown command first, then begin and single accesses, then wrap and burst limits
    script[0]  = '{'{CMD_PING,        8'h21, 8'h00, 8'h00, 8'h00, 7'd0},   1'b1, ST_NOTSTARTED, 8'h00};
    script[1]  = '{'{CMD_WRITE_REG,   8'h00, 8'h10, 8'h99, 8'h00, 7'd0},   1'b1, ST_NOTSTARTED, 8'h00};
    script[2]  = '{'{CMD_BURST_READ,  8'h00, 8'h00, 8'h00, 8'h00, 7'd5},   1'b1, ST_NOTSTARTED, 8'h00};
    script[3]  = '{'{CMD_UNKNOWN_7,   8'hFF, 8'hFF, 8'hFF, 8'hFF, 7'd127}, 1'b1, ST_OK,         8'h00};
    script[4]  = '{'{CMD_BEGIN,       8'h00, 8'h00, 8'h00, 8'h00, 7'd0},   1'b1, ST_OK,         8'h00};
    script[5]  = '{'{CMD_BEGIN,       8'h33, 8'h00, 8'h00, 8'h00, 7'd0},   1'b1, ST_OK,         8'h00};
    script[6]  = '{'{CMD_PING,        8'h00, 8'h00, 8'h00, 8'h00, 7'd0},   1'b1, ST_OK,         8'h00};
    script[7]  = '{'{CMD_PING,        8'h33, 8'h00, 8'h00, 8'h00, 7'd0},   1'b1, ST_NODEV,      8'h00};
    script[8]  = '{'{CMD_READ_REG,    8'hFF, 8'hFF, 8'h00, 8'h00, 7'd0},   1'b1, ST_OK,         8'h00};
    script[9]  = '{'{CMD_WRITE_REG,   8'h00, 8'h00, 8'hFF, 8'h00, 7'd0},   1'b1, ST_OK,         8'h00};
    script[10] = '{'{CMD_WRITE_REG,   8'hFF, 8'hFF, 8'hAA, 8'h00, 7'd0},   1'b1, ST_OK,         8'h00};
    script[11] = '{'{CMD_READ_REG,    8'h00, 8'h00, 8'h00, 8'h00, 7'd0},   1'b0, ST_OK,         8'h00};
    script[12] = '{'{CMD_READ_REG,    8'hFF, 8'hFF, 8'h00, 8'h00, 7'd0},   1'b0, ST_OK,         8'h00};
    script[13] = '{'{CMD_BURST_WRITE, 8'h50, 8'hF0, 8'h55, 8'h20, 7'd0},   1'b1, ST_OK,         8'h00};
    script[14] = '{'{CMD_BURST_WRITE, 8'h50, 8'hFF, 8'h01, 8'hFF, 7'd0},   1'b1, ST_OK,         8'h00};
    script[15] = '{'{CMD_BURST_READ,  8'h50, 8'h0E, 8'h00, 8'h00, 7'd4},   1'b0, ST_OK,         8'h00};
    script[16] = '{'{CMD_BURST_READ,  8'hFF, 8'hFE, 8'h00, 8'h00, 7'd3},   1'b0, ST_OK,         8'h00};
    script[17] = '{'{CMD_BURST_READ,  8'h00, 8'h00, 8'h00, 8'h00, 7'd0},   1'b0, ST_OK,         8'h00};
    script[18] = '{'{CMD_BURST_READ,  8'h81, 8'hE0, 8'h00, 8'h00, 7'd64},  1'b0, ST_OK,         8'h00};
    script[19] = '{'{CMD_BURST_READ,  8'h12, 8'hF8, 8'h00, 8'h00, 7'd127}, 1'b0, ST_OK,         8'h00};
    script[20] = '{'{CMD_BURST_READ,  8'h33, 8'h00, 8'h00, 8'h00, 7'd10},  1'b1, ST_NODEV,      8'h00};
    script[21] = '{'{CMD_WRITE_REG,   8'h33, 8'h01, 8'h77, 8'h00, 7'd0},   1'b1, ST_NODEV,      8'h00};
    script[22] = '{'{CMD_UNKNOWN_6,   8'h00, 8'h00, 8'h00, 8'h00, 7'd0},   1'b1, ST_OK,         8'h00};
    script[23] = '{'{CMD_READ_REG,    8'h5A, 8'h80, 8'h00, 8'h00, 7'd0},   1'b0, ST_OK,         8'h00};
    script[24] = '{'{CMD_BURST_WRITE, 8'h81, 8'h7F, 8'h7E, 8'h80, 7'd0},   1'b1, ST_OK,         8'h00};

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // slot 12 repeats the address of slot 3, the lower slot must answer
    set_bank(64'h7F3C_A512_5021_FF00, 64'h81E0_4450_0FC3_995A, 5'd16);
    foreach (script[k]) begin
      put_item(script[k].item, script[k].typed, '{script[k].st, script[k].rd, 1'b1});
    end
    drain();

    set_bank({$urandom, $urandom}, {$urandom, $urandom}, 5'd16);
    random_run(60);
    set_bank({$urandom, $urandom}, {$urandom, $urandom}, 5'd0);
    random_run(15);
    // count above the slot total saturates
    set_bank({$urandom, $urandom}, 64'hFFFF_FFFF_FFFF_FFFF, 5'd31);
    random_run(50);
    set_bank({$urandom, $urandom}, {$urandom, $urandom}, 5'd1);
    random_run(40);
    set_bank({$urandom, $urandom}, {$urandom, $urandom}, DEVCNT_W'($urandom_range(2, 15)));
    random_run(55);

    repeat (80) @(negedge clk);
    if (pending_replies.size() != 0) begin
      note_mismatch($sformatf("%0d expected results never arrived", pending_replies.size()));
    end

    $display("run: %0d items (%0d directed), %0d burst reads, six bank settings incl. none",
             items_sent, N_SCRIPT, burst_reads);
    $display("      active and a saturated count; %0d results checked, %0d mismatches",
             checked, mismatches);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== i2c_target_register_bank.f =====
src/i2ctrb_pkg.sv
src/i2ctrb_ram.sv
src/i2ctrb_datapath.sv
src/i2ctrb_ctrl.sv
src/i2c_target_register_bank.sv
tb/i2c_target_register_bank_tb.sv
